/* sv/flash_write_frame_packer_assert.svh */
// assertion macros shared by the frame packer
`ifndef FLASH_WRITE_FRAME_PACKER_ASSERT_SVH
`define FLASH_WRITE_FRAME_PACKER_ASSERT_SVH

// condition must hold in the same cycle
`define FWFP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame packer check failed");

// condition must hold in the next cycle
`define FWFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame packer check failed");

`endif

/* sv/fwfp_pkg.sv */
package fwfp_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_BUF_LENGTH    = 2'd0;
   localparam logic [1:0] CSR_BUF_ALIGN     = 2'd1;
   localparam logic [1:0] CSR_BLOCK_COMMAND = 2'd2;
   localparam logic [1:0] CSR_CHECKSUM_INIT = 2'd3;

   // word kinds on the frame
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_OFFSET = 2'd1;
   localparam logic [1:0] KIND_DATA   = 2'd2;
   localparam logic [1:0] KIND_CHECK  = 2'd3;

   localparam logic [1:0]  LANE_LAST    = 2'd3;
   localparam logic [31:0] WORD_ERASED  = 32'hffff_ffff;
   localparam logic [15:0] LENGTH_RESET = 16'd4;
   localparam logic [15:0] ALIGN_RESET  = 16'd1;

   // one classified request waiting for the back end
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first;
      logic [31:0] start_offset;
      logic [31:0] transfer_left;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_HEADER,
      ST_OFFSET,
      ST_PACK,
      ST_WORD,
      ST_CHECK
   } back_state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [15:0] remainder;
   } div_rsp_type;

endpackage

/* sv/flash_write_frame_packer.sv */
// a byte inside a run passes through the back end's idle and pack states, and the word state when it
// completes a data word; a byte that opens a run first waits in the divide state for the offset modulo
// in the serial divider, then the header and offset words go out; the checksum word follows the last data word
// the front end queues requests, so req_ready stays high until the queue fills
// synchronous active-high reset: buf_length 4, buf_align 1, command and checksum seed 0,
// no transfer open, queue and output register empty
module flash_write_frame_packer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel, one byte per request
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   input  logic [31:0] req_start_offset,
   input  logic [31:0] req_byte_count,
   // frame word channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_frame_word,
   output logic [1:0]  rsp_word_kind,
   output logic        rsp_last,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import fwfp_pkg::*;

   `include "flash_write_frame_packer_assert.svh"

   // configuration registers
   logic [15:0] buf_length_ff, buf_length_in;
   logic [15:0] buf_align_ff, buf_align_in;
   logic [31:0] block_command_ff, block_command_in;
   logic [31:0] checksum_init_ff, checksum_init_in;

   // front to back queue
   logic        queue_push;
   logic        queue_ready;
   entry_type   push_entry;
   logic        queue_pop;
   logic        queue_valid;
   entry_type   pop_entry;

   // modulo unit
   div_req_type div_req;
   div_rsp_type div_rsp;

   // the user must issue writes only while idle; the block does not enforce this, and the port is always open
   assign csr_ready = 1'b1;

   always_comb begin
      buf_length_in    = buf_length_ff;
      buf_align_in     = buf_align_ff;
      block_command_in = block_command_ff;
      checksum_init_in = checksum_init_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BUF_LENGTH:    buf_length_in    = csr_wdata[15:0];
            CSR_BUF_ALIGN:     buf_align_in     = csr_wdata[15:0];
            CSR_BLOCK_COMMAND: block_command_in = csr_wdata;
            CSR_CHECKSUM_INIT: checksum_init_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_length_ff    <= LENGTH_RESET;
         buf_align_ff     <= ALIGN_RESET;
         block_command_ff <= '0;
         checksum_init_ff <= '0;
      end else begin
         buf_length_ff    <= buf_length_in;
         buf_align_ff     <= buf_align_in;
         block_command_ff <= block_command_in;
         checksum_init_ff <= checksum_init_in;
      end
   end

   // front end: drops stray bytes, tracks what is left of the transfer
   fwfp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_first        (req_first),
      .req_start_offset (req_start_offset),
      .req_byte_count   (req_byte_count),
      .queue_ready      (queue_ready),
      .queue_push       (queue_push),
      .queue_entry      (push_entry)
   );

   fwfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .push_ready (queue_ready),
      .pop        (queue_pop),
      .pop_valid  (queue_valid),
      .pop_entry  (pop_entry)
   );

   // serial offset modulo alignment, used once per run
   fwfp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // back end: run split, byte packing, checksum, output register
   fwfp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .buf_length     (buf_length_ff),
      .buf_align      (buf_align_ff),
      .block_command  (block_command_ff),
      .checksum_init  (checksum_init_ff),
      .queue_valid    (queue_valid),
      .queue_entry    (pop_entry),
      .queue_pop      (queue_pop),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_word (rsp_frame_word),
      .rsp_word_kind  (rsp_word_kind),
      .rsp_last       (rsp_last)
   );

   // only the checksum word closes a run
   `FWFP_ASSERT_NOW(a_last_on_check, rsp_valid, rsp_last == (rsp_word_kind == KIND_CHECK))
   // a new modulo never starts over one in flight
   `FWFP_ASSERT_NOW(a_div_start_idle, div_req.start, !div_rsp.busy)
   // a started modulo is running on the next cycle
   `FWFP_ASSERT_NEXT(a_div_runs, div_req.start, div_rsp.busy && !div_rsp.done)

endmodule

/* sv/fwfp_queue.sv */
module fwfp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fwfp_pkg::entry_type push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                pop_valid,
   output fwfp_pkg::entry_type pop_entry
);
   import fwfp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST   = PW'(DEPTH - 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

   entry_type     slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != COUNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* sv/fwfp_front.sv */
module fwfp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_first,
   input  logic [31:0]         req_start_offset,
   input  logic [31:0]         req_byte_count,
   input  logic                queue_ready,
   output logic                queue_push,
   output fwfp_pkg::entry_type queue_entry
);
   import fwfp_pkg::*;

   logic [31:0] transfer_left_ff, transfer_left_in;
   logic [31:0] left_now;
   logic        accept;
   logic        keep;

   assign req_ready = queue_ready;
   assign accept    = req_valid && req_ready;

   // stray bytes and empty transfers are dropped here
   always_comb begin
      left_now         = req_first ? req_byte_count : transfer_left_ff;
      keep             = (left_now != '0);
      transfer_left_in = transfer_left_ff;
      if (accept) begin
         transfer_left_in = keep ? left_now - 1'b1 : left_now;
      end
      queue_push                = accept && keep;
      queue_entry.data_byte     = req_data_byte;
      queue_entry.first         = req_first;
      queue_entry.start_offset  = req_start_offset;
      queue_entry.transfer_left = left_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         transfer_left_ff <= '0;
      end else begin
         transfer_left_ff <= transfer_left_in;
      end
   end

endmodule

/* sv/fwfp_div.sv */
module fwfp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fwfp_pkg::div_req_type div_req,
   output fwfp_pkg::div_rsp_type div_rsp
);
   import fwfp_pkg::*;

   localparam logic [5:0] STEPS = 6'd32;

   logic [5:0]  count_ff, count_in;
   logic [31:0] dividend_ff, dividend_in;
   logic [15:0] divisor_ff, divisor_in;
   logic [15:0] rem_ff, rem_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic        fits;

   // restoring remainder, one quotient bit per cycle
   always_comb begin
      trial       = {rem_ff, dividend_ff[31]};
      fits        = (trial >= {1'b0, divisor_ff});
      count_in    = count_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      done_in     = 1'b0;
      if (div_req.start) begin
         count_in    = STEPS;
         dividend_in = div_req.dividend;
         divisor_in  = div_req.divisor;
         rem_in      = '0;
      end else if (count_ff != '0) begin
         count_in    = count_ff - 1'b1;
         dividend_in = {dividend_ff[30:0], 1'b0};
         rem_in      = fits ? 16'(trial - {1'b0, divisor_ff}) : trial[15:0];
         done_in     = (count_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign div_rsp.busy      = (count_ff != '0);
   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

/* sv/fwfp_back.sv */
module fwfp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           buf_length,
   input  logic [15:0]           buf_align,
   input  logic [31:0]           block_command,
   input  logic [31:0]           checksum_init,
   input  logic                  queue_valid,
   input  fwfp_pkg::entry_type   queue_entry,
   output logic                  queue_pop,
   output fwfp_pkg::div_req_type div_req,
   input  fwfp_pkg::div_rsp_type div_rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_frame_word,
   output logic [1:0]            rsp_word_kind,
   output logic                  rsp_last
);
   import fwfp_pkg::*;

   back_state_type state_ff, state_in;
   entry_type      entry_ff, entry_in;
   logic [15:0]    run_left_ff, run_left_in;
   logic [31:0]    cur_offset_ff, cur_offset_in;
   logic [15:0]    residue_ff, residue_in;
   logic [1:0]     lane_ff, lane_in;
   logic [31:0]    acc_ff, acc_in;
   logic [31:0]    csum_ff, csum_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_word_ff, rsp_word_in;
   logic [1:0]     rsp_kind_ff, rsp_kind_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           out_free;
   logic           need_run;
   logic [32:0]    span;
   logic [15:0]    run_len;
   logic [31:0]    merged;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign need_run = queue_entry.first || (run_left_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (queue_valid) begin
               state_in = need_run ? ST_DIV : ST_PACK;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_HEADER;
            end
         end
         ST_HEADER: begin
            if (out_free) begin
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            if (out_free) begin
               state_in = ST_PACK;
            end
         end
         ST_PACK: begin
            state_in = (lane_ff == LANE_LAST || run_left_ff == 16'd1) ? ST_WORD : ST_IDLE;
         end
         ST_WORD: begin
            if (out_free) begin
               state_in = (run_left_ff == '0) ? ST_CHECK : ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      entry_in      = entry_ff;
      run_left_in   = run_left_ff;
      cur_offset_in = cur_offset_ff;
      residue_in    = residue_ff;
      lane_in       = lane_ff;
      acc_in        = acc_ff;
      csum_in       = csum_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      queue_pop     = 1'b0;

      div_req.start    = 1'b0;
      div_req.dividend = queue_entry.first ? queue_entry.start_offset : cur_offset_ff;
      div_req.divisor  = (buf_align == '0) ? ALIGN_RESET : buf_align;

      span = {1'b0, entry_ff.transfer_left} + {17'd0, div_rsp.remainder};
      if (span > {17'd0, buf_length}) begin
         run_len = (buf_length > div_rsp.remainder) ? buf_length - div_rsp.remainder : 16'd1;
      end else begin
         run_len = entry_ff.transfer_left[15:0];
      end

      merged = acc_ff;
      merged[{lane_ff, 3'b000} +: 8] = acc_ff[{lane_ff, 3'b000} +: 8] & entry_ff.data_byte;

      case (state_ff)
         ST_IDLE: begin
            if (queue_valid) begin
               queue_pop     = 1'b1;
               entry_in      = queue_entry;
               div_req.start = need_run;
               if (queue_entry.first) begin
                  cur_offset_in = queue_entry.start_offset;
                  run_left_in   = '0;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               residue_in  = div_rsp.remainder;
               run_left_in = run_len;
               lane_in     = div_rsp.remainder[1:0];
               acc_in      = WORD_ERASED;
               csum_in     = checksum_init;
            end
         end
         ST_HEADER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = block_command | {16'd0, run_left_ff};
               rsp_kind_in  = KIND_HEADER;
               rsp_last_in  = 1'b0;
            end
         end
         ST_OFFSET: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = cur_offset_ff;
               rsp_kind_in  = KIND_OFFSET;
               rsp_last_in  = 1'b0;
            end
         end
         ST_PACK: begin
            acc_in        = merged;
            lane_in       = lane_ff + 1'b1;
            run_left_in   = run_left_ff - 1'b1;
            cur_offset_in = cur_offset_ff + 1'b1;
         end
         ST_WORD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = acc_ff;
               rsp_kind_in  = KIND_DATA;
               rsp_last_in  = 1'b0;
               csum_in      = csum_ff ^ acc_ff;
               acc_in       = WORD_ERASED;
               lane_in      = '0;
            end
         end
         ST_CHECK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = csum_ff;
               rsp_kind_in  = KIND_CHECK;
               rsp_last_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         run_left_ff   <= '0;
         cur_offset_ff <= '0;
         residue_ff    <= '0;
         lane_ff       <= '0;
         acc_ff        <= WORD_ERASED;
         csum_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         run_left_ff   <= run_left_in;
         cur_offset_ff <= cur_offset_in;
         residue_ff    <= residue_in;
         lane_ff       <= lane_in;
         acc_ff        <= acc_in;
         csum_ff       <= csum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      rsp_word_ff <= rsp_word_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_word = rsp_word_ff;
   assign rsp_word_kind  = rsp_kind_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
